@@ src/mpba_pkg.sv @@
// ----------------------------------------------------------------------------
// mpba_pkg
// Shared types, constants and address helpers of the multi-pool allocator.
// ----------------------------------------------------------------------------
package mpba_pkg;

  localparam int HeapBytes = 4096;
  localparam int PoolLimit = 4;
  localparam int AddrW     = 12;
  localparam int SizeW     = 13;
  localparam int CountW    = 3;
  localparam int PoolW     = 2;
  localparam int ReqW      = 16;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 13;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgPoolCount  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgBlockSize0 = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgBlockSize3 = 3'd4;

  typedef enum logic [1:0] {
    ACT_INIT  = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_FREE  = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_BLOCK = 2'd1,
    ST_CFG_BAD  = 2'd2,
    ST_NOT_INIT = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    DP_NONE,
    DP_INIT_START,
    DP_INIT_STEP,
    DP_ALLOC_READ,
    DP_ALLOC_DONE,
    DP_FREE,
    DP_RESULT
  } dp_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_INIT,
    S_ALLOC,
    S_WAIT
  } fsm_e;

  typedef struct packed {
    logic    capture;
    dp_op_e  op;
    status_e res_status;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    action_e action;
    logic    cfg_ok;
    logic    ready;
    logic    hit;
    logic    init_last;
    logic    out_free;
  } dp_stat_t;

  // Bytes of heap that each pool owns for a given pool count.
  function automatic logic [SizeW-1:0] share_of(input logic [CountW-1:0] count);
    logic [SizeW-1:0] s;
    case (count)
      3'd1:    s = SizeW'(HeapBytes / 1);
      3'd2:    s = SizeW'(HeapBytes / 2);
      3'd3:    s = SizeW'(HeapBytes / 3);
      3'd4:    s = SizeW'(HeapBytes / 4);
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [AddrW-1:0] pool_start(input logic [PoolW-1:0]  idx,
                                                  input logic [CountW-1:0] count);
    logic [SizeW+1:0] prod;
    prod = (SizeW+2)'(idx) * (SizeW+2)'(share_of(count));
    return prod[AddrW-1:0];
  endfunction

  // One past the last byte of a pool.
  function automatic logic [SizeW-1:0] pool_stop(input logic [PoolW-1:0]  idx,
                                                 input logic [CountW-1:0] count);
    logic [SizeW+1:0] prod;
    prod = ((SizeW+2)'(idx) + (SizeW+2)'(1)) * (SizeW+2)'(share_of(count));
    return prod[SizeW-1:0];
  endfunction

endpackage

@@ src/mpba_ram.sv @@
// ----------------------------------------------------------------------------
// mpba_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module mpba_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/mpba_ctrl.sv @@
// ----------------------------------------------------------------------------
// mpba_ctrl
// Sequencer of the allocator: accepts a request, steps the datapath through
// initialize, allocate or free, and hands the result to the output register.
// ----------------------------------------------------------------------------
module mpba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mpba_pkg::dp_stat_t stat_i,
  output mpba_pkg::dp_cmd_t  cmd_o
);

  mpba_pkg::fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mpba_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    in_ready_o       = 1'b0;
    cmd_o.capture    = 1'b0;
    cmd_o.op         = mpba_pkg::DP_NONE;
    cmd_o.res_status = mpba_pkg::ST_OK;
    cmd_o.out_load   = 1'b0;
    case (state_q)
      mpba_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = mpba_pkg::S_DECODE;
        end
      end
      mpba_pkg::S_DECODE: begin
        state_d = mpba_pkg::S_WAIT;
        case (stat_i.action)
          mpba_pkg::ACT_INIT: begin
            if (stat_i.cfg_ok) begin
              cmd_o.op = mpba_pkg::DP_INIT_START;
              state_d  = mpba_pkg::S_INIT;
            end else begin
              cmd_o.op         = mpba_pkg::DP_RESULT;
              cmd_o.res_status = mpba_pkg::ST_CFG_BAD;
            end
          end
          mpba_pkg::ACT_ALLOC: begin
            if (!stat_i.ready) begin
              cmd_o.op         = mpba_pkg::DP_RESULT;
              cmd_o.res_status = mpba_pkg::ST_NOT_INIT;
            end else if (!stat_i.hit) begin
              cmd_o.op         = mpba_pkg::DP_RESULT;
              cmd_o.res_status = mpba_pkg::ST_NO_BLOCK;
            end else begin
              cmd_o.op = mpba_pkg::DP_ALLOC_READ;
              state_d  = mpba_pkg::S_ALLOC;
            end
          end
          mpba_pkg::ACT_FREE: begin
            if (!stat_i.ready) begin
              cmd_o.op         = mpba_pkg::DP_RESULT;
              cmd_o.res_status = mpba_pkg::ST_NOT_INIT;
            end else begin
              cmd_o.op = mpba_pkg::DP_FREE;
            end
          end
          default: begin
            cmd_o.op         = mpba_pkg::DP_RESULT;
            cmd_o.res_status = mpba_pkg::ST_OK;
          end
        endcase
      end
      mpba_pkg::S_INIT: begin
        cmd_o.op = mpba_pkg::DP_INIT_STEP;
        if (stat_i.init_last) begin
          state_d = mpba_pkg::S_WAIT;
        end
      end
      mpba_pkg::S_ALLOC: begin
        cmd_o.op = mpba_pkg::DP_ALLOC_DONE;
        state_d  = mpba_pkg::S_WAIT;
      end
      mpba_pkg::S_WAIT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = mpba_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = mpba_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ src/mpba_datapath.sv @@
// ----------------------------------------------------------------------------
// mpba_datapath
// Configuration registers, pool heads and flags, the list-building walker,
// the link memory and the output register of the allocator.
// ----------------------------------------------------------------------------
module mpba_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [mpba_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [mpba_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic [1:0]                           in_action_i,
  input  logic [mpba_pkg::ReqW-1:0]            in_req_i,
  input  logic [mpba_pkg::AddrW-1:0]           in_addr_i,
  input  mpba_pkg::dp_cmd_t                    cmd_i,
  output mpba_pkg::dp_stat_t                   stat_o,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic [1:0]                           out_status_o,
  output logic [mpba_pkg::AddrW-1:0]           out_block_o,
  output logic [mpba_pkg::PoolW-1:0]           out_pool_o,
  output logic                                 out_full_o
);

  localparam int AW = mpba_pkg::AddrW;
  localparam int SW = mpba_pkg::SizeW;
  localparam int CW = mpba_pkg::CountW;
  localparam int PW = mpba_pkg::PoolW;
  localparam int NP = mpba_pkg::PoolLimit;

  // Configuration and live pool layout.
  logic [CW-1:0] cfg_count_q;
  logic [SW-1:0] cfg_size_q [NP];
  logic [CW-1:0] live_count_q;
  logic [SW-1:0] live_size_q [NP];
  logic [AW-1:0] head_q [NP];
  logic [NP-1:0] full_q;
  logic          ready_q;

  // Captured request.
  mpba_pkg::action_e action_q;
  logic [mpba_pkg::ReqW-1:0] req_q;
  logic [AW-1:0]             addr_q;

  // List-building walker.
  logic [PW-1:0] wpool_q;
  logic [AW-1:0] wj_q;
  logic [AW-1:0] wbegin_q;
  logic [AW-1:0] wlast_q;
  logic [SW-1:0] wsize_q;

  // Allocate in flight, pending result and output register.
  logic [PW-1:0] sel_q;
  logic [AW-1:0] blk_q;
  logic [1:0]    res_status_q;
  logic [AW-1:0] res_blk_q;
  logic [PW-1:0] res_pool_q;
  logic          res_full_q;
  logic          out_valid_q;
  logic [1:0]    out_status_q;
  logic [AW-1:0] out_blk_q;
  logic [PW-1:0] out_pool_q;
  logic          out_full_q;

  logic          cfg_ok;
  logic          hit;
  logic [PW-1:0] hit_idx;
  logic [PW-1:0] own_idx;
  logic [SW-1:0] wsum;
  logic          wmore;
  logic [AW-1:0] wnext;
  logic          wlast_pool;
  logic [PW-1:0] np_idx;
  logic [SW-1:0] np_end;
  logic [SW-1:0] first_end;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [AW-1:0] ram_wdata;
  logic [AW-1:0] ram_rdata;
  logic [CW-1:0] cfg_sel;

  // Configuration check: count in range and every used size between 2 and the share.
  always_comb begin
    cfg_ok = cfg_count_q inside {[CW'(1) : CW'(NP)]};
    for (int i = 0; i < NP; i++) begin
      if (CW'(i) < cfg_count_q &&
          (cfg_size_q[i] < SW'(2) || cfg_size_q[i] > mpba_pkg::share_of(cfg_count_q))) begin
        cfg_ok = 1'b0;
      end
    end
  end

  // First pool in index order that fits the request and still has a block.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = NP - 1; i >= 0; i--) begin
      if (CW'(i) < live_count_q && !full_q[i] &&
          {{(mpba_pkg::ReqW - SW){1'b0}}, live_size_q[i]} >= req_q) begin
        hit     = 1'b1;
        hit_idx = PW'(i);
      end
    end
  end

  // Owning pool of a freed address; falls back to the last live pool.
  always_comb begin
    own_idx = PW'(live_count_q - CW'(1));
    for (int i = NP - 2; i >= 0; i--) begin
      if (CW'(i) + CW'(1) < live_count_q &&
          addr_q < mpba_pkg::pool_start(PW'(i + 1), live_count_q)) begin
        own_idx = PW'(i);
      end
    end
  end

  // Walker: the link of the block at wj_q, and where to go next.
  assign wsum       = SW'(wj_q) + wsize_q;
  assign wmore      = wsum <= {1'b0, wlast_q};
  assign wnext      = wmore ? wsum[AW-1:0] : wbegin_q;
  assign wlast_pool = ({1'b0, wpool_q} + CW'(1)) >= live_count_q;
  assign np_idx     = wpool_q + PW'(1);
  assign np_end     = mpba_pkg::pool_stop(np_idx, live_count_q) - live_size_q[np_idx];
  assign first_end  = mpba_pkg::pool_stop(PW'(0), cfg_count_q) - cfg_size_q[0];

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = addr_q;
    ram_wdata = head_q[own_idx];
    case (cmd_i.op)
      mpba_pkg::DP_INIT_STEP: begin
        ram_we    = 1'b1;
        ram_addr  = wj_q;
        ram_wdata = wnext;
      end
      mpba_pkg::DP_ALLOC_READ: begin
        ram_addr = head_q[hit_idx];
      end
      mpba_pkg::DP_FREE: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  mpba_ram #(
    .WIDTH (AW),
    .DEPTH (mpba_pkg::HeapBytes)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign cfg_sel = cfg_index_i - mpba_pkg::CfgBlockSize0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_count_q    <= CW'(1);
      cfg_size_q[0]  <= SW'(16);
      cfg_size_q[1]  <= SW'(32);
      cfg_size_q[2]  <= SW'(64);
      cfg_size_q[3]  <= SW'(128);
      live_count_q   <= '0;
      ready_q        <= 1'b0;
      full_q         <= '0;
      out_valid_q    <= 1'b0;
      for (int i = 0; i < NP; i++) begin
        live_size_q[i] <= '0;
        head_q[i]      <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == mpba_pkg::CfgPoolCount) begin
          cfg_count_q <= cfg_data_i[CW-1:0];
        end else if (cfg_index_i inside {[mpba_pkg::CfgBlockSize0 : mpba_pkg::CfgBlockSize3]}) begin
          cfg_size_q[cfg_sel[PW-1:0]] <= cfg_data_i[SW-1:0];
        end
      end

      case (cmd_i.op)
        mpba_pkg::DP_INIT_START: begin
          live_count_q <= cfg_count_q;
          ready_q      <= 1'b1;
          for (int i = 0; i < NP; i++) begin
            live_size_q[i] <= cfg_size_q[i];
            if (CW'(i) < cfg_count_q) begin
              head_q[i] <= mpba_pkg::pool_start(PW'(i), cfg_count_q);
              full_q[i] <= 1'b0;
            end
          end
        end
        mpba_pkg::DP_ALLOC_DONE: begin
          head_q[sel_q] <= ram_rdata;
          if (ram_rdata == mpba_pkg::pool_start(sel_q, live_count_q)) begin
            full_q[sel_q] <= 1'b1;
          end
        end
        mpba_pkg::DP_FREE: begin
          full_q[own_idx] <= 1'b0;
          head_q[own_idx] <= addr_q;
        end
        default: begin
        end
      endcase

      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      action_q <= mpba_pkg::action_e'(in_action_i);
      req_q    <= in_req_i;
      addr_q   <= in_addr_i;
    end

    case (cmd_i.op)
      mpba_pkg::DP_INIT_START: begin
        wpool_q  <= '0;
        wj_q     <= '0;
        wbegin_q <= '0;
        wlast_q  <= first_end[AW-1:0];
        wsize_q  <= cfg_size_q[0];
      end
      mpba_pkg::DP_INIT_STEP: begin
        if (wmore) begin
          wj_q <= wsum[AW-1:0];
        end else if (!wlast_pool) begin
          wpool_q  <= np_idx;
          wj_q     <= mpba_pkg::pool_start(np_idx, live_count_q);
          wbegin_q <= mpba_pkg::pool_start(np_idx, live_count_q);
          wlast_q  <= np_end[AW-1:0];
          wsize_q  <= live_size_q[np_idx];
        end else begin
          res_status_q <= mpba_pkg::ST_OK;
          res_blk_q    <= '0;
          res_pool_q   <= '0;
          res_full_q   <= 1'b0;
        end
      end
      mpba_pkg::DP_ALLOC_READ: begin
        sel_q <= hit_idx;
        blk_q <= head_q[hit_idx];
      end
      mpba_pkg::DP_ALLOC_DONE: begin
        res_status_q <= mpba_pkg::ST_OK;
        res_blk_q    <= blk_q;
        res_pool_q   <= sel_q;
        res_full_q   <= ram_rdata == mpba_pkg::pool_start(sel_q, live_count_q);
      end
      mpba_pkg::DP_FREE: begin
        res_status_q <= mpba_pkg::ST_OK;
        res_blk_q    <= '0;
        res_pool_q   <= own_idx;
        res_full_q   <= 1'b0;
      end
      mpba_pkg::DP_RESULT: begin
        res_status_q <= cmd_i.res_status;
        res_blk_q    <= '0;
        res_pool_q   <= '0;
        res_full_q   <= 1'b0;
      end
      default: begin
      end
    endcase

    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_blk_q    <= res_blk_q;
      out_pool_q   <= res_pool_q;
      out_full_q   <= res_full_q;
    end
  end

  assign stat_o.action    = action_q;
  assign stat_o.cfg_ok    = cfg_ok;
  assign stat_o.ready     = ready_q;
  assign stat_o.hit       = hit;
  assign stat_o.init_last = !wmore && wlast_pool;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_block_o  = out_blk_q;
  assign out_pool_o   = out_pool_q;
  assign out_full_o   = out_full_q;

endmodule

@@ src/multi_pool_block_allocator.sv @@
// ----------------------------------------------------------------------------
// multi_pool_block_allocator
// Fixed-block allocator over a 4096-byte heap split into up to four pools.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel: tuser carries the action (initialize,
// allocate, free, no-op), tdata the request size and the release address.
// Every request gives exactly one result on the m_axis channel: tuser carries
// the status, tdata the block address, the pool index and the now-full flag.
// Pool count and block sizes are written through the cfg port; the user must
// write them only while the block is idle, as the block itself does not
// enforce it. They take effect at the next initialize.
// An allocate result passes decode, one registered read of the link memory
// and the output load. Free, no-op and rejected requests go from decode to
// the output load. An initialize writes one link per cycle until every block
// of all pools is linked. The next request is accepted in the cycle after the
// output load. The link memory port serves initialize, allocate and free.
// One request is in work at a time; a new one is accepted once the previous
// result sits in the output register, even while the receiver stalls it.
// After reset no pool is ready and allocate or free report not initialized;
// the link memory is not cleared, since every link is written before use.
// ----------------------------------------------------------------------------
module multi_pool_block_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // request_size [15:0], release_address [27:16], zeros above
  input  logic [31:0] s_axis_tdata,
  // action [1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // block_address [11:0], pool_index [13:12], pool_now_full [14], zero [15]
  output logic [15:0] m_axis_tdata,
  // status [1:0]
  output logic [1:0]  m_axis_tuser
);

  mpba_pkg::dp_cmd_t  cmd;
  mpba_pkg::dp_stat_t stat;

  logic [mpba_pkg::AddrW-1:0] out_block;
  logic [mpba_pkg::PoolW-1:0] out_pool;
  logic                       out_full;

  mpba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mpba_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_action_i  (s_axis_tuser),
    .in_req_i     (s_axis_tdata[15:0]),
    .in_addr_i    (s_axis_tdata[27:16]),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (m_axis_tuser),
    .out_block_o  (out_block),
    .out_pool_o   (out_pool),
    .out_full_o   (out_full)
  );

  assign m_axis_tdata = {1'b0, out_full, out_pool, out_block};

endmodule
